[hdl/mcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mcs_pkg;
	localparam int ACC_W = 48;
	localparam int VAL_W = 16;
	localparam int SUM_W = 32;
	localparam int ROOT_W = 31;
	localparam int DEN_W = 62;
	localparam int QMAX = 65536;

	typedef struct packed {
		logic acc_en;
		logic acc_clr;
		logic ld_a;
		logic ld_b;
		logic norm_step;
		logic root_init;
		logic root_step;
		logic root_save;
		logic mul_init;
		logic mul_step;
		logic div_init;
		logic div_step;
		logic finish;
		logic set_clr;
	} mcs_cmd_t;

	typedef struct packed {
		logic norm_done;
		logic root_done;
		logic mul_done;
		logic div_done;
		logic zero_norm;
		logic mean_done;
	} mcs_sts_t;
endpackage
`default_nettype wire

[hdl/mean_cosine_similarity.sv]
// Mean cosine similarity engine.
// Input channel: link_value/node_value pairs (Q4.12) with last_element and
// last_node, on valid/stall. One request is taken per cycle while a node is
// being accumulated. After the request with last_element the input stalls
// while the node is finished: each norm is scaled by 4 until one of its top
// two bits is set, then its square root is taken one bit pair per cycle, with
// a load step between the norms; then come the root product (shift-add), the
// bit-serial division, and closing and publishing the result. A set-closing
// node adds the mean division.
// Output channel: one request per node, node_similarity (Q1.15), and on the
// last node of a set also mean_similarity and set_done. The result is held
// in an output register until taken; a stalled output holds the block before
// the next result is written, so nothing is lost.
// Reset clears the dot-product and norm accumulators, the set sum, node count and output valid.
// Zero-norm nodes give similarity 0 and still count toward the mean.
`timescale 1ns / 1ps
`default_nettype none
module mean_cosine_similarity
	import mcs_pkg::*;
#(
	parameter int MAX_ELEMENTS = 1024,
	parameter int MAX_NODES = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [15:0] link_value,
	input  wire logic signed [15:0] node_value,
	input  wire logic last_element,
	input  wire logic last_node,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [15:0] node_similarity,
	output logic signed [15:0] mean_similarity,
	output logic set_done
);
	localparam int CNT_W = $clog2(MAX_NODES + 1) + ((MAX_ELEMENTS > 0) ? 0 : 1);
	mcs_cmd_t cmd;
	mcs_sts_t sts;

	mcs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .last_element,
		.out_valid, .out_stall, .cmd, .sts
	);

	mcs_datapath #(.CNT_W(CNT_W), .MAX_NODES(MAX_NODES)) u_dp (
		.clk, .arst_n, .cmd, .sts, .link_value, .node_value, .last_node,
		.node_similarity, .mean_similarity, .set_done
	);

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_element) |=> in_stall)
		else $error("input not stalled after node end");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(node_similarity))
		else $error("result changed while stalled");
	a_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !set_done) |-> (mean_similarity == '0))
		else $error("mean set without set end");
endmodule
`default_nettype wire

[hdl/mcs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcs_datapath
	import mcs_pkg::*;
#(
	parameter int CNT_W = 9,
	parameter int MAX_NODES = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mcs_cmd_t cmd,
	output mcs_sts_t sts,
	input  wire logic signed [VAL_W-1:0] link_value,
	input  wire logic signed [VAL_W-1:0] node_value,
	input  wire logic last_node,
	output logic signed [VAL_W-1:0] node_similarity,
	output logic signed [VAL_W-1:0] mean_similarity,
	output logic set_done
);
	localparam int QC_W = 8;
	localparam int MC_W = 6;

	// accumulators
	logic [ACC_W-1:0] dot_q, ln_q, nn_q;
	logic signed [2*VAL_W-1:0] pd, pl, pn;
	assign pd = link_value * node_value;
	assign pl = link_value * link_value;
	assign pn = node_value * node_value;
	logic [ACC_W-1:0] dot_n, ln_n, nn_n;
	assign dot_n = dot_q + ACC_W'(pd);
	assign ln_n = ln_q + ACC_W'(pl);
	assign nn_n = nn_q + ACC_W'(pn);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			ln_q <= '0;
			nn_q <= '0;
		end else if (cmd.acc_clr) begin
			dot_q <= '0;
			ln_q <= '0;
			nn_q <= '0;
		end else if (cmd.acc_en) begin
			dot_q <= dot_n;
			ln_q <= ln_n;
			nn_q <= nn_n;
		end
	end

	// snapshot of finished node
	logic [ACC_W-1:0] mag_q, nb_q;
	logic neg_q, last_q;
	logic [DEN_W-1:0] x_q;
	logic [5:0] k_q, ka_q;
	logic [DEN_W-1:0] v_q, r_q, bit_q;
	logic [ROOT_W-1:0] ra_q, rb_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] macc_q;
	logic [ROOT_W-1:0] mb_q;
	logic [MC_W-1:0] mc_q;
	logic [DEN_W:0] rem_q;
	logic [QC_W-1:0] qcnt_q;
	logic [QC_W-1:0] qlen_q;
	logic [17:0] q_q;
	logic sat_q;
	logic zero_q;

	// a zero norm needs no scaling
	assign sts.norm_done = x_q[DEN_W-1] | x_q[DEN_W-2] | (x_q == '0);
	assign sts.root_done = (bit_q == '0);
	assign sts.mul_done = (mc_q == MC_W'(ROOT_W));
	assign sts.div_done = sat_q | (qcnt_q == qlen_q);
	assign sts.zero_norm = zero_q;

	logic [DEN_W-1:0] rb_sum;
	assign rb_sum = r_q + bit_q;
	logic [DEN_W:0] rem_sh;
	logic in_bit;
	assign in_bit = (qcnt_q < QC_W'(ACC_W)) ? mag_q[ACC_W-1 - 6'(qcnt_q)] : 1'b0;
	assign rem_sh = {rem_q[DEN_W-1:0], in_bit};
	logic [17:0] q_next;
	logic ge;
	assign ge = rem_sh >= {1'b0, den_q};
	assign q_next = {q_q[16:0], ge};

	always_ff @(posedge clk) begin
		if (cmd.ld_a) begin
			mag_q <= dot_n[ACC_W-1] ? (~dot_n + 1'b1) : dot_n;
			neg_q <= dot_n[ACC_W-1];
			nb_q <= nn_n;
			zero_q <= (ln_n == '0) || (nn_n == '0);
			last_q <= last_node;
			x_q <= DEN_W'(ln_n);
			k_q <= '0;
		end else if (cmd.ld_b) begin
			x_q <= DEN_W'(nb_q);
			ka_q <= k_q;
			k_q <= '0;
		end else if (cmd.norm_step) begin
			x_q <= x_q << 2;
			k_q <= k_q + 1'b1;
		end
		if (cmd.root_init) begin
			v_q <= x_q;
			r_q <= '0;
			bit_q <= DEN_W'(1) << (DEN_W-2);
		end else if (cmd.root_step) begin
			if (v_q >= rb_sum) begin
				v_q <= v_q - rb_sum;
				r_q <= (r_q >> 1) + bit_q;
			end else
				r_q <= r_q >> 1;
			bit_q <= bit_q >> 2;
		end
		if (cmd.root_save) begin
			ra_q <= rb_q;
			rb_q <= r_q[ROOT_W-1:0];
		end
		// issued with the second root's save: multiplier takes the fresh root
		if (cmd.mul_init) begin
			macc_q <= '0;
			mb_q <= r_q[ROOT_W-1:0];
			mc_q <= '0;
		end else if (cmd.mul_step) begin
			if (mb_q[ROOT_W-1 - 5'(mc_q)])
				macc_q <= (macc_q << 1) + DEN_W'(ra_q);
			else
				macc_q <= macc_q << 1;
			mc_q <= mc_q + 1'b1;
		end
		if (cmd.div_init) begin
			den_q <= macc_q;
			rem_q <= '0;
			q_q <= '0;
			qcnt_q <= '0;
			qlen_q <= QC_W'(ACC_W + 15) + QC_W'(ka_q) + QC_W'(k_q);
			sat_q <= 1'b0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			q_q <= q_next;
			qcnt_q <= qcnt_q + 1'b1;
			if (q_next > 18'(QMAX)) sat_q <= 1'b1;
		end
	end

	// similarity result
	logic signed [VAL_W-1:0] sim;
	always_comb begin
		if (zero_q) sim = '0;
		else if (neg_q)
			sim = (sat_q || q_q >= 18'd32768) ? -16'sd32768 : VAL_W'(-$signed({1'b0, q_q}));
		else
			sim = (sat_q || q_q > 18'd32767) ? 16'sd32767 : VAL_W'(q_q);
	end

	// set accumulation and mean (restoring division of |sum| by count)
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [SUM_W:0] s_ext;
	assign s_ext = sum_q + sim;
	logic [SUM_W-1:0] dmag_q, dq_q;
	logic [CNT_W:0] drem_q;
	logic [5:0] dc_q;
	logic dneg_q, dbusy_q, mbusy_q;
	logic [CNT_W:0] drem_sh;
	assign drem_sh = {drem_q[CNT_W-1:0], dmag_q[SUM_W-1 - 5'(dc_q)]};
	logic dge;
	assign dge = drem_sh >= {1'b0, cnt_q};
	assign sts.mean_done = !mbusy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			mbusy_q <= 1'b0;
			dbusy_q <= 1'b0;
			dc_q <= '0;
			dneg_q <= 1'b0;
			dmag_q <= '0;
			drem_q <= '0;
			dq_q <= '0;
			node_similarity <= '0;
			mean_similarity <= '0;
			set_done <= 1'b0;
		end else if (cmd.finish) begin
			node_similarity <= sim;
			mean_similarity <= '0;
			set_done <= last_q;
			if (s_ext > $signed(33'sh07fffffff)) sum_q <= 32'sh7fffffff;
			else if (s_ext < -$signed(33'sh080000000)) sum_q <= 32'sh80000000;
			else sum_q <= SUM_W'(s_ext);
			if (32'(cnt_q) < 32'(MAX_NODES)) cnt_q <= cnt_q + 1'b1;
			if (last_q) begin
				mbusy_q <= 1'b1;
				dbusy_q <= 1'b0;
			end
		end else if (mbusy_q && !dbusy_q) begin
			dneg_q <= sum_q[SUM_W-1];
			dmag_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			drem_q <= '0;
			dq_q <= '0;
			dc_q <= '0;
			dbusy_q <= 1'b1;
		end else if (dbusy_q) begin
			drem_q <= dge ? drem_sh - {1'b0, cnt_q} : drem_sh;
			dq_q <= {dq_q[SUM_W-2:0], dge};
			dc_q <= dc_q + 1'b1;
			if (dc_q == 6'(SUM_W-1)) begin
				dbusy_q <= 1'b0;
				mbusy_q <= 1'b0;
				if (dneg_q)
					mean_similarity <= ({dq_q[SUM_W-2:0], dge} >= 32'd32768) ?
						-16'sd32768 : VAL_W'(-{dq_q[SUM_W-2:0], dge});
				else
					mean_similarity <= ({dq_q[SUM_W-2:0], dge} > 32'd32767) ?
						16'sd32767 : VAL_W'({dq_q[SUM_W-2:0], dge});
				sum_q <= '0;
				cnt_q <= '0;
			end
		end else if (cmd.set_clr) begin
			sum_q <= sum_q;
		end
	end
endmodule
`default_nettype wire

[hdl/mcs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcs_ctrl
	import mcs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic last_element,
	output logic out_valid,
	input  wire logic out_stall,
	output mcs_cmd_t cmd,
	input  wire mcs_sts_t sts
);
	typedef enum logic [3:0] {
		ST_ACC, ST_NORM_A, ST_ROOT_A, ST_LD_B, ST_NORM_B, ST_ROOT_B,
		ST_MUL, ST_DIV, ST_FIN, ST_MEAN, ST_OUT
	} state_t;
	state_t state_q;
	logic rinit_q;

	logic accept;
	logic out_free;
	assign in_stall = (state_q != ST_ACC);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		cmd = '0;
		cmd.acc_en = accept;
		cmd.ld_a = accept && last_element;
		cmd.acc_clr = (state_q == ST_NORM_A) && rinit_q;
		case (state_q)
			ST_NORM_A, ST_NORM_B: begin
				if (!sts.norm_done) cmd.norm_step = 1'b1;
				else cmd.root_init = 1'b1;
			end
			ST_ROOT_A, ST_ROOT_B: begin
				if (!sts.root_done) cmd.root_step = 1'b1;
				else cmd.root_save = 1'b1;
			end
			ST_LD_B: cmd.ld_b = 1'b1;
			ST_MUL: begin
				if (!sts.mul_done) cmd.mul_step = 1'b1;
				else cmd.div_init = 1'b1;
			end
			ST_DIV: cmd.div_step = !sts.div_done;
			ST_FIN: cmd.finish = out_free;
			default: ;
		endcase
		if (state_q == ST_ROOT_B && sts.root_done) cmd.mul_init = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			rinit_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			rinit_q <= 1'b0;
			case (state_q)
				ST_ACC: if (accept && last_element) begin
					state_q <= ST_NORM_A;
					rinit_q <= 1'b1;
				end
				ST_NORM_A: if (sts.norm_done) state_q <= ST_ROOT_A;
				ST_ROOT_A: if (sts.root_done) state_q <= ST_LD_B;
				ST_LD_B: state_q <= ST_NORM_B;
				ST_NORM_B: if (sts.norm_done) state_q <= ST_ROOT_B;
				ST_ROOT_B: if (sts.root_done) state_q <= ST_MUL;
				ST_MUL: if (sts.mul_done) state_q <= ST_DIV;
				ST_DIV: if (sts.div_done) state_q <= ST_FIN;
				ST_FIN: if (out_free) state_q <= ST_MEAN;
				ST_MEAN: if (sts.mean_done) state_q <= ST_OUT;
				ST_OUT: begin
					out_valid <= 1'b1;
					state_q <= ST_ACC;
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end
endmodule
`default_nettype wire
